@@ rtl/yaz0_pkg.sv @@
// Shared types, sizes and constants of the Yaz0 stream decompressor.
// No dependencies; every other file imports this package.
package yaz0_pkg;

  localparam int unsigned HISTORY_DEPTH = 4096;
  localparam int unsigned OUT_BYTES     = 8;
  localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned HIST_CW       = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned FILL_W        = $clog2(OUT_BYTES + 1);
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned DIST_W        = 12;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam logic [7:0] FLAG_MSB      = 8'h80;
  localparam logic [7:0] LONG_LEN_BIAS = 8'h12;
  localparam logic       CFG_SKIP      = 1'b0;
  localparam logic       CFG_MAX       = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_done;
    logic        bad_magic;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ERROR,
    CMD_HDR_END,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              clear;
    logic [7:0]        lit_byte;
    logic [DIST_W-1:0] copy_dist;
    logic [LEN_W-1:0]  len;
    logic [31:0]       limit;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_CODE,
    PH_REF1,
    PH_REF2
  } phase_e;

  typedef enum logic {
    BK_IDLE,
    BK_COPY
  } back_state_e;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h59;
      2'd1: b = 8'h61;
      2'd2: b = 8'h7a;
      2'd3: b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/yaz0_stream_decompressor.sv @@
// Top level of the Yaz0 stream decompressor: configuration registers,
// front end, command queue and back end. Uses yaz0_pkg and all rtl modules.
//
// Input channel: one compressed byte per beat (in_valid_i / in_stall_o);
// start_of_stream marks header byte 0 and restarts parsing and counters.
// Output channel: packed results of up to eight bytes (out_valid_o /
// out_stall_i), first byte in the low bits, run_last on an item's last one.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i, always ready;
// index 0 is skip_count, index 1 is max_output. Write only when idle.
// Throughput: the front end takes one byte a cycle while the queue has room.
// Code bytes and plain header bytes stay in the front end; the bad magic
// error, the header end and a literal are handled as the back end pops
// them; a back-reference pops, reads the ring and then pushes one byte a
// cycle while the output is not stalled, via one read and one write port of the ring.
// Order: a result loads into the output register as its last byte is
// pushed; a literal is pushed as the back end pops it; a copy reads the
// ring on its pop, then pushes its bytes. The queue holds four commands.
// Reset clears all control state; a fill count makes never-written ring
// entries read as zero. A stalled receiver holds the output register; the
// back end then holds, the queue fills and in_stall_o rises.
module yaz0_stream_decompressor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  yaz0_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output yaz0_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import yaz0_pkg::*;

  logic [31:0] skip_q, max_q;
  logic        cmd_push, cmd_full, cmd_pop, cmd_valid;
  cmd_t        cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 32'd0;
      max_q  <= 32'hffff_ffff;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SKIP: skip_q <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  yaz0_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .skip_i      (skip_q),
    .max_i       (max_q),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  yaz0_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_push),
    .push_data_i (cmd_in),
    .full_o      (cmd_full),
    .pop_i       (cmd_pop),
    .valid_o     (cmd_valid),
    .pop_data_o  (cmd_out)
  );

  yaz0_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .skip_i      (skip_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/yaz0_front.sv @@
// Front end: accepts stream bytes, parses the header and code bytes and
// issues at most one command per beat into the command queue. Uses yaz0_pkg.
module yaz0_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  yaz0_pkg::in_item_t in_data_i,
  input  logic [31:0]        skip_i,
  input  logic [31:0]        max_i,
  output logic               cmd_valid_o,
  output yaz0_pkg::cmd_t     cmd_o,
  input  logic               cmd_full_i
);
  import yaz0_pkg::*;

  logic              accept;
  logic              sos;
  logic [4:0]        hidx_q, hidx_d, hidx_c;
  logic [31:0]       len_q, len_d, len_c;
  logic [7:0]        flag_q, flag_d, flag_c;
  logic [3:0]        fbits_q, fbits_d, fbits_c;
  phase_e            phase_q, phase_d, phase_c;
  logic [7:0]        t0_q, t0_d, t0_c;
  logic [DIST_W-1:0] dist_q, dist_d, dist_c;
  logic              abort_q, abort_d, abort_c;
  logic [31:0]       lim_sub, lim;
  logic [7:0]        b;
  cmd_t              cmd;

  assign in_stall_o = cmd_full_i;
  assign accept     = in_valid_i && !cmd_full_i;
  assign sos        = in_data_i.start_of_stream;
  assign b          = in_data_i.in_byte;

  always_comb begin
    hidx_c  = sos ? 5'd0 : hidx_q;
    len_c   = sos ? 32'd0 : len_q;
    flag_c  = sos ? 8'd0 : flag_q;
    fbits_c = sos ? 4'd0 : fbits_q;
    phase_c = sos ? PH_CODE : phase_q;
    t0_c    = sos ? 8'd0 : t0_q;
    dist_c  = sos ? '0 : dist_q;
    abort_c = sos ? 1'b0 : abort_q;

    hidx_d  = hidx_c;
    len_d   = len_c;
    flag_d  = flag_c;
    fbits_d = fbits_c;
    phase_d = phase_c;
    t0_d    = t0_c;
    dist_d  = dist_c;
    abort_d = abort_c;

    lim_sub = (len_c > skip_i) ? (len_c - skip_i) : 32'd0;
    lim     = (lim_sub > max_i) ? max_i : lim_sub;

    cmd          = '0;
    cmd.kind     = CMD_NOP;
    cmd.clear    = sos;
    cmd.lit_byte = b;
    cmd.limit    = lim;

    if (!abort_c) begin
      if (hidx_c < 5'(HEADER_BYTES)) begin
        if (hidx_c < 5'd4) begin
          if (b != magic_byte(hidx_c[1:0])) begin
            abort_d  = 1'b1;
            cmd.kind = CMD_ERROR;
          end
        end else if (hidx_c < 5'd8) begin
          len_d = {len_c[23:0], b};
        end
        if (!abort_d) begin
          if (hidx_c == 5'(HEADER_BYTES - 1)) begin
            cmd.kind = CMD_HDR_END;
          end
          hidx_d = hidx_c + 5'd1;
        end
      end else begin
        case (phase_c)
          PH_REF1: begin
            dist_d = {t0_c[3:0], b};
            if (t0_c[7:4] != 4'd0) begin
              cmd.kind      = CMD_COPY;
              cmd.copy_dist = {t0_c[3:0], b};
              cmd.len       = LEN_W'(t0_c[7:4]) + LEN_W'(2);
              flag_d        = {flag_c[6:0], 1'b0};
              fbits_d       = (fbits_c != 4'd0) ? fbits_c - 4'd1 : fbits_c;
              phase_d       = PH_CODE;
            end else begin
              phase_d = PH_REF2;
            end
          end
          PH_REF2: begin
            cmd.kind      = CMD_COPY;
            cmd.copy_dist = dist_c;
            cmd.len       = LEN_W'(b) + LEN_W'(LONG_LEN_BIAS);
            flag_d        = {flag_c[6:0], 1'b0};
            fbits_d       = (fbits_c != 4'd0) ? fbits_c - 4'd1 : fbits_c;
            phase_d       = PH_CODE;
          end
          PH_CODE: begin
            if (fbits_c == 4'd0) begin
              flag_d  = b;
              fbits_d = 4'd8;
            end else if ((flag_c & FLAG_MSB) != 8'd0) begin
              cmd.kind = CMD_LIT;
              flag_d   = {flag_c[6:0], 1'b0};
              fbits_d  = fbits_c - 4'd1;
            end else begin
              t0_d    = b;
              phase_d = PH_REF1;
            end
          end
          default: phase_d = PH_CODE;
        endcase
      end
    end
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept && ((cmd.kind != CMD_NOP) || cmd.clear);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hidx_q  <= '0;
      len_q   <= '0;
      flag_q  <= '0;
      fbits_q <= '0;
      phase_q <= PH_CODE;
      t0_q    <= '0;
      dist_q  <= '0;
      abort_q <= 1'b0;
    end else if (accept) begin
      hidx_q  <= hidx_d;
      len_q   <= len_d;
      flag_q  <= flag_d;
      fbits_q <= fbits_d;
      phase_q <= phase_d;
      t0_q    <= t0_d;
      dist_q  <= dist_d;
      abort_q <= abort_d;
    end
  end

endmodule

@@ rtl/yaz0_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
// Uses yaz0_pkg for the command type and depth.
module yaz0_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  yaz0_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output yaz0_pkg::cmd_t pop_data_o
);
  import yaz0_pkg::*;

  cmd_t               slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o     = (cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW + 1)'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - (FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

@@ rtl/yaz0_back.sv @@
// Back end: runs commands against the history ring, packs emitted bytes
// and holds the output register. Uses yaz0_pkg.
module yaz0_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  yaz0_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic [31:0]         skip_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output yaz0_pkg::out_item_t out_data_o
);
  import yaz0_pkg::*;

  logic [7:0] mem [HISTORY_DEPTH];

  back_state_e             state_q, state_d;
  logic [HIST_AW-1:0]      wp_q, src_q, src_d, raddr, copy_src;
  logic [HIST_AW:0]        src_tmp;
  logic [HIST_CW-1:0]      hfill_q;
  logic [31:0]             decoded_q, emitted_q, explen_q;
  logic                    done_q;
  logic [8*OUT_BYTES-1:0]  word_q, word_n;
  logic [FILL_W-1:0]       fill_q, fill_n;
  logic [LEN_W-1:0]        rem_q, rem_d;
  logic [7:0]              rdata_q, fwd_data_q, cur_byte, push_byte;
  logic                    rvalid_q, fwd_q;
  logic                    ovalid_q;
  out_item_t               opay_q;
  logic                    out_free, pop, clr, hdr_load, err_fire;
  logic                    push_en, push_last, push_go, emit, done_now, fire, adv;
  logic                    rd_en, wr_en;

  function automatic logic [HIST_AW-1:0] ring_inc(input logic [HIST_AW-1:0] x);
    return (x == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : x + HIST_AW'(1);
  endfunction

  assign out_free = !ovalid_q || !out_stall_i;
  assign cur_byte = fwd_q ? fwd_data_q : (rvalid_q ? rdata_q : 8'd0);

  assign src_tmp  = {1'b0, wp_q} - (HIST_AW + 1)'(cmd_i.copy_dist) - (HIST_AW + 1)'(1);
  assign copy_src = src_tmp[HIST_AW] ?
                    HIST_AW'(src_tmp + (HIST_AW + 1)'(HISTORY_DEPTH)) :
                    src_tmp[HIST_AW-1:0];

  assign emit     = (decoded_q >= skip_i);
  assign fill_n   = fill_q + FILL_W'(1);
  assign word_n   = word_q | ((8*OUT_BYTES)'(push_byte) << (8 * fill_q));
  assign done_now = push_en && emit &&
                    (({1'b0, emitted_q} + 33'd1) >= {1'b0, explen_q});
  assign fire     = push_en && emit &&
                    (done_now || (fill_n == FILL_W'(OUT_BYTES)) || push_last);
  assign adv      = !fire || out_free;
  assign push_go  = push_en && adv;
  assign wr_en    = push_go && !done_now;

  always_comb begin
    state_d   = state_q;
    src_d     = src_q;
    rem_d     = rem_q;
    pop       = 1'b0;
    hdr_load  = 1'b0;
    err_fire  = 1'b0;
    push_en   = 1'b0;
    push_last = 1'b0;
    push_byte = cmd_i.lit_byte;
    rd_en     = 1'b0;
    raddr     = src_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          pop = 1'b1;
          case (cmd_i.kind)
            CMD_ERROR:   err_fire = 1'b1;
            CMD_HDR_END: hdr_load = 1'b1;
            CMD_LIT: begin
              if (!done_q) begin
                push_en   = 1'b1;
                push_last = 1'b1;
              end
            end
            CMD_COPY: begin
              if (!done_q) begin
                rd_en   = 1'b1;
                raddr   = copy_src;
                src_d   = ring_inc(copy_src);
                rem_d   = cmd_i.len;
                state_d = BK_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      BK_COPY: begin
        push_en   = 1'b1;
        push_byte = cur_byte;
        push_last = (rem_q == LEN_W'(1));
        if (adv) begin
          rd_en = 1'b1;
          src_d = ring_inc(src_q);
          rem_d = rem_q - LEN_W'(1);
          if (push_last || done_now) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign clr       = pop && cmd_i.clear;
  assign cmd_pop_o = pop;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wp_q] <= push_byte;
    end
    if (rd_en) begin
      rdata_q    <= mem[raddr];
      fwd_data_q <= push_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      src_q     <= '0;
      rem_q     <= '0;
      wp_q      <= '0;
      hfill_q   <= '0;
      decoded_q <= '0;
      emitted_q <= '0;
      explen_q  <= '0;
      done_q    <= 1'b0;
      word_q    <= '0;
      fill_q    <= '0;
      rvalid_q  <= 1'b0;
      fwd_q     <= 1'b0;
      ovalid_q  <= 1'b0;
      opay_q    <= '0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      rem_q   <= rem_d;
      if (rd_en) begin
        rvalid_q <= (HIST_CW'(raddr) < hfill_q);
        fwd_q    <= wr_en && (raddr == wp_q);
      end
      if (clr) begin
        wp_q      <= '0;
        decoded_q <= '0;
        emitted_q <= '0;
        explen_q  <= '0;
        done_q    <= 1'b0;
      end
      if (hdr_load) begin
        explen_q <= cmd_i.limit;
        done_q   <= (cmd_i.limit == 32'd0);
      end
      if (push_go && emit) begin
        emitted_q <= emitted_q + 32'd1;
        if (fire) begin
          word_q <= '0;
          fill_q <= '0;
        end else begin
          word_q <= word_n;
          fill_q <= fill_n;
        end
      end
      if (push_go && done_now) begin
        done_q <= 1'b1;
      end
      if (wr_en) begin
        wp_q <= ring_inc(wp_q);
        if ((hfill_q == HIST_CW'(wp_q)) && (hfill_q != HIST_CW'(HISTORY_DEPTH))) begin
          hfill_q <= hfill_q + HIST_CW'(1);
        end
        if (decoded_q != 32'hffff_ffff) begin
          decoded_q <= decoded_q + 32'd1;
        end
      end
      if (err_fire) begin
        ovalid_q <= 1'b1;
        opay_q   <= '{data_word: '0, byte_count: '0, run_last: 1'b1,
                      stream_done: 1'b0, bad_magic: 1'b1};
      end else if (fire && push_go) begin
        ovalid_q <= 1'b1;
        opay_q   <= '{data_word: 64'(word_n), byte_count: 4'(fill_n),
                      run_last: done_now || push_last, stream_done: done_now,
                      bad_magic: 1'b0};
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = opay_q;

endmodule
